// File: rtl/gce_pkg.sv
// Shared types and constants for the grid clearance edge cost block.
package gce_pkg;

   localparam int PIX_W     = 12;
   localparam int CELL_W    = 6;
   localparam int MARGIN_W  = 4;
   localparam int SIZE_W    = 7;
   localparam int REGION_W  = 7;
   localparam int COST_W    = 9;
   localparam int COUNT_W   = 3;
   localparam int DIV_CNT_W = 4;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int COST_STEP = 25;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd3;
   localparam logic [SIZE_W-1:0]   SIZE_RESET   = 7'd1;
   localparam logic [REGION_W-1:0] REGION_RESET = 7'd64;

   localparam logic [1:0] CSR_MARGIN    = 2'd0;
   localparam logic [1:0] CSR_CELL_SIZE = 2'd1;
   localparam logic [1:0] CSR_ROWS      = 2'd2;
   localparam logic [1:0] CSR_COLS      = 2'd3;

   localparam logic [0:0] REQ_WRITE = 1'b0;
   localparam logic [0:0] REQ_QUERY = 1'b1;

   localparam logic signed [1:0] NB_DR  [0:3] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0};
   localparam logic signed [1:0] NB_DC  [0:3] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1};
   localparam logic signed [1:0] RAY_DR [0:7] =
      '{-2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] RAY_DC [0:7] =
      '{2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_NB_CHK,
      ST_NB_WAIT,
      ST_RAY_CHK,
      ST_RAY_WAIT,
      ST_OUT
   } gce_state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic div_step;
      logic nb_next;
      logic ray_first;
      logic ray_step;
      logic ray_next;
      logic ray_read;
      logic set_hit;
      logic set_clear;
      logic out_load;
   } gce_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_query;
      logic div_last;
      logic outside;
      logic nb_in;
      logic nb_last;
      logic rd_wall;
      logic mg_zero;
      logic ray_in;
      logic ray_last;
      logic ray_end;
      logic out_full;
   } gce_sts_type;

endpackage

// File: rtl/gce_ctrl.sv
// Controller state machine that sequences clearing, division, neighbour and ray scans.
module gce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gce_pkg::gce_sts_type sts,
   output gce_pkg::gce_cmd_type cmd
);
   import gce_pkg::*;

   gce_state_type state_ff, state_in;
   logic          nb_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      nb_done   = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.req_query) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.outside ? ST_OUT : ST_NB_CHK;
         end
         ST_NB_CHK: begin
            if (sts.nb_in) begin
               state_in = ST_NB_WAIT;
            end else begin
               nb_done = 1'b1;
            end
         end
         ST_NB_WAIT: begin
            if (sts.rd_wall) begin
               nb_done = 1'b1;
            end else if (sts.mg_zero) begin
               cmd.set_clear = 1'b1;
               nb_done       = 1'b1;
            end else begin
               cmd.ray_first = 1'b1;
               state_in      = ST_RAY_CHK;
            end
         end
         ST_RAY_CHK: begin
            if (sts.ray_in) begin
               cmd.ray_read = 1'b1;
               state_in     = ST_RAY_WAIT;
            end else if (sts.ray_last) begin
               cmd.set_clear = 1'b1;
               nb_done       = 1'b1;
            end else begin
               cmd.ray_next = 1'b1;
            end
         end
         ST_RAY_WAIT: begin
            if (sts.rd_wall) begin
               cmd.set_hit = 1'b1;
               nb_done     = 1'b1;
            end else if (sts.ray_end) begin
               if (sts.ray_last) begin
                  cmd.set_clear = 1'b1;
                  nb_done       = 1'b1;
               end else begin
                  cmd.ray_next = 1'b1;
                  state_in     = ST_RAY_CHK;
               end
            end else begin
               cmd.ray_step = 1'b1;
               state_in     = ST_RAY_CHK;
            end
         end
         ST_OUT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (nb_done) begin
         if (sts.nb_last) begin
            state_in = ST_OUT;
         end else begin
            cmd.nb_next = 1'b1;
            state_in    = ST_NB_CHK;
         end
      end
   end

endmodule

// File: rtl/gce_dp.sv
// Datapath with the occupancy memory, pixel divider, scan counters and result register.
module gce_dp #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int MAX_MARGIN = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [gce_pkg::MARGIN_W-1:0]   cfg_margin,
   input  logic [gce_pkg::SIZE_W-1:0]     cfg_cell_size,
   input  logic [gce_pkg::REGION_W-1:0]   cfg_rows,
   input  logic [gce_pkg::REGION_W-1:0]   cfg_cols,
   input  logic                           req_type,
   input  logic [gce_pkg::CELL_W-1:0]     req_cell_row,
   input  logic [gce_pkg::CELL_W-1:0]     req_cell_col,
   input  logic                           req_cell_occupied,
   input  logic [gce_pkg::PIX_W-1:0]      req_pixel_x,
   input  logic [gce_pkg::PIX_W-1:0]      req_pixel_y,
   input  gce_pkg::gce_cmd_type           cmd,
   output gce_pkg::gce_sts_type           sts,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_up_free,
   output logic [gce_pkg::COST_W-1:0]     rsp_up_cost,
   output logic                           rsp_down_free,
   output logic [gce_pkg::COST_W-1:0]     rsp_down_cost,
   output logic                           rsp_left_free,
   output logic [gce_pkg::COST_W-1:0]     rsp_left_cost,
   output logic                           rsp_right_free,
   output logic [gce_pkg::COST_W-1:0]     rsp_right_cost,
   output logic [gce_pkg::COUNT_W-1:0]    rsp_free_count
);
   import gce_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 2 ** AW;
   localparam int NRW   = $clog2(MAX_ROWS + 1);
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int MGW   = $clog2(MAX_MARGIN + 1);
   localparam int MX1   = (NRW > NCW) ? NRW : NCW;
   localparam int PW    = ((MX1 > MGW) ? MX1 : MGW) + 2;

   logic occ_mem [0:DEPTH-1];

   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 rd_ff;
   logic [PIX_W-1:0]     qx_ff, qx_in, qy_ff, qy_in;
   logic [SIZE_W-1:0]    rx_ff, rx_in, ry_ff, ry_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [1:0]           k_ff, k_in;
   logic [2:0]           ray_ff, ray_in;
   logic [MGW-1:0]       d_ff, d_in;
   logic                 free_ff [0:3];
   logic                 free_in [0:3];
   logic [COST_W-1:0]    cost_ff [0:3];
   logic [COST_W-1:0]    cost_in [0:3];
   logic                 valid_ff, valid_in;
   logic                 o_free_ff [0:3];
   logic [COST_W-1:0]    o_cost_ff [0:3];
   logic [COUNT_W-1:0]   o_count_ff;

   logic [SIZE_W-1:0]    divisor;
   logic [SIZE_W:0]      trial_x, trial_y;
   logic [NRW-1:0]       nr;
   logic [NCW-1:0]       nc;
   logic [MGW-1:0]       mg;
   logic [31:0]          qx32, qy32, wr_row32, wr_col32, prod;
   logic signed [PW-1:0] row_s, col_s, nb_r, nb_c, ray_r, ray_c, rd_r, rd_c;
   logic signed [PW-1:0] d_s, nr_s, nc_s, off_r, off_c;
   logic [MGW-1:0]       dist_w;
   logic [COST_W-1:0]    hit_cost;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 wr_en, wr_data, wr_ok;

   // Effective configuration.
   always_comb begin
      divisor = (cfg_cell_size == '0) ? SIZE_W'(1) : cfg_cell_size;
      nr = (32'(cfg_rows) > MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(cfg_rows);
      nc = (32'(cfg_cols) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(cfg_cols);
      mg = (32'(cfg_margin) > MAX_MARGIN) ? MGW'(MAX_MARGIN) : MGW'(cfg_margin);
   end

   // Positions of the cell, neighbour and ray probe.
   always_comb begin
      qx32  = 32'(qx_ff);
      qy32  = 32'(qy_ff);
      row_s = $signed(qy32[PW-1:0]);
      col_s = $signed(qx32[PW-1:0]);
      nr_s  = $signed(PW'(nr));
      nc_s  = $signed(PW'(nc));
      d_s   = $signed(PW'(d_ff));
      nb_r  = row_s + PW'(NB_DR[k_ff]);
      nb_c  = col_s + PW'(NB_DC[k_ff]);
      off_r = (RAY_DR[ray_ff] < 0) ? -d_s : ((RAY_DR[ray_ff] > 0) ? d_s : '0);
      off_c = (RAY_DC[ray_ff] < 0) ? -d_s : ((RAY_DC[ray_ff] > 0) ? d_s : '0);
      ray_r = nb_r + off_r;
      ray_c = nb_c + off_c;
      rd_r  = cmd.ray_read ? ray_r : nb_r;
      rd_c  = cmd.ray_read ? ray_c : nb_c;
      rd_addr = {rd_r[RW-1:0], rd_c[CW-1:0]};
   end

   // Cost of a wall met at the current distance.
   always_comb begin
      dist_w   = MGW'(mg - d_ff + MGW'(1));
      prod     = 32'(dist_w) * 32'(COST_STEP);
      hit_cost = prod[COST_W-1:0];
   end

   // Memory write port: clearing sweep or cell write item.
   always_comb begin
      wr_row32 = 32'(req_cell_row);
      wr_col32 = 32'(req_cell_col);
      wr_ok    = (wr_row32 < MAX_ROWS) && (wr_col32 < MAX_COLS);
      wr_en    = cmd.clr_step || (cmd.accept && (req_type == REQ_WRITE) && wr_ok);
      wr_data  = cmd.clr_step ? 1'b0 : req_cell_occupied;
      wr_addr  = cmd.clr_step ? clr_addr_ff : {wr_row32[RW-1:0], wr_col32[CW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         occ_mem[wr_addr] <= wr_data;
      end
      rd_ff <= occ_mem[rd_addr];
   end

   always_comb begin
      trial_x = {rx_ff, qx_ff[PIX_W-1]};
      trial_y = {ry_ff, qy_ff[PIX_W-1]};
   end

   always_comb begin
      clr_addr_in = cmd.clr_step ? clr_addr_ff + AW'(1) : clr_addr_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      div_cnt_in  = div_cnt_ff;
      k_in        = k_ff;
      ray_in      = ray_ff;
      d_in        = d_ff;
      free_in     = free_ff;
      cost_in     = cost_ff;
      valid_in    = valid_ff && rsp_stall;
      if (cmd.accept) begin
         qx_in      = req_pixel_x;
         qy_in      = req_pixel_y;
         rx_in      = '0;
         ry_in      = '0;
         div_cnt_in = '0;
         k_in       = '0;
         for (int i = 0; i < 4; i++) begin
            free_in[i] = 1'b0;
            cost_in[i] = '0;
         end
      end
      if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
         if (trial_x >= {1'b0, divisor}) begin
            rx_in = SIZE_W'(trial_x - {1'b0, divisor});
            qx_in = {qx_ff[PIX_W-2:0], 1'b1};
         end else begin
            rx_in = trial_x[SIZE_W-1:0];
            qx_in = {qx_ff[PIX_W-2:0], 1'b0};
         end
         if (trial_y >= {1'b0, divisor}) begin
            ry_in = SIZE_W'(trial_y - {1'b0, divisor});
            qy_in = {qy_ff[PIX_W-2:0], 1'b1};
         end else begin
            ry_in = trial_y[SIZE_W-1:0];
            qy_in = {qy_ff[PIX_W-2:0], 1'b0};
         end
      end
      if (cmd.nb_next) begin
         k_in = k_ff + 2'd1;
      end
      if (cmd.ray_first) begin
         ray_in = '0;
         d_in   = MGW'(1);
      end
      if (cmd.ray_step) begin
         d_in = d_ff + MGW'(1);
      end
      if (cmd.ray_next) begin
         ray_in = ray_ff + 3'd1;
         d_in   = MGW'(1);
      end
      if (cmd.set_hit) begin
         free_in[k_ff] = 1'b1;
         cost_in[k_ff] = hit_cost;
      end
      if (cmd.set_clear) begin
         free_in[k_ff] = 1'b1;
         cost_in[k_ff] = COST_W'(1);
      end
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         valid_ff    <= 1'b0;
         div_cnt_ff  <= '0;
         k_ff        <= '0;
         ray_ff      <= '0;
         d_ff        <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         valid_ff    <= valid_in;
         div_cnt_ff  <= div_cnt_in;
         k_ff        <= k_in;
         ray_ff      <= ray_in;
         d_ff        <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      free_ff <= free_in;
      cost_ff <= cost_in;
      if (cmd.out_load) begin
         o_free_ff  <= free_ff;
         o_cost_ff  <= cost_ff;
         o_count_ff <= COUNT_W'(free_ff[0]) + COUNT_W'(free_ff[1])
                     + COUNT_W'(free_ff[2]) + COUNT_W'(free_ff[3]);
      end
   end

   always_comb begin
      sts.clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
      sts.req_query = (req_type == REQ_QUERY);
      sts.div_last  = (div_cnt_ff == DIV_CNT_W'(PIX_W - 1));
      sts.outside   = (32'(qy_ff) >= 32'(nr)) || (32'(qx_ff) >= 32'(nc));
      sts.nb_in     = (nb_r >= 0) && (nb_r < nr_s) && (nb_c >= 0) && (nb_c < nc_s);
      sts.nb_last   = (k_ff == 2'd3);
      sts.rd_wall   = rd_ff;
      sts.mg_zero   = (mg == '0);
      sts.ray_in    = (ray_r >= 0) && (ray_r < nr_s) && (ray_c >= 0) && (ray_c < nc_s);
      sts.ray_last  = (ray_ff == 3'd7);
      sts.ray_end   = (d_ff == mg);
      sts.out_full  = valid_ff && rsp_stall;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_up_free    = o_free_ff[0];
   assign rsp_up_cost    = o_cost_ff[0];
   assign rsp_down_free  = o_free_ff[1];
   assign rsp_down_cost  = o_cost_ff[1];
   assign rsp_left_free  = o_free_ff[2];
   assign rsp_left_cost  = o_cost_ff[2];
   assign rsp_right_free = o_free_ff[3];
   assign rsp_right_cost = o_cost_ff[3];
   assign rsp_free_count = o_count_ff;

endmodule

// File: rtl/grid_clearance_edge_cost_core.sv
// Top level: register port, controller and datapath of the clearance edge cost block.
// A write item goes to the occupancy memory as it is accepted. A query item divides the
// pixel position by the cell size, then scans the neighbours and their rays in the memory.
// One item is worked on at a time; the result register lets the next item in while it waits.
// After reset a clearing pass zeroes all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) words
// (4096 by default) of the occupancy memory; no item is taken until it ends.
module grid_clearance_edge_cost_core #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int MAX_MARGIN = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gce_pkg::CSR_AW-1:0]   paddr,
   input  logic [gce_pkg::CSR_DW-1:0]   pwdata,
   output logic [gce_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [gce_pkg::CELL_W-1:0]   req_cell_row,
   input  logic [gce_pkg::CELL_W-1:0]   req_cell_col,
   input  logic                         req_cell_occupied,
   input  logic [gce_pkg::PIX_W-1:0]    req_pixel_x,
   input  logic [gce_pkg::PIX_W-1:0]    req_pixel_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_up_free,
   output logic [gce_pkg::COST_W-1:0]   rsp_up_cost,
   output logic                         rsp_down_free,
   output logic [gce_pkg::COST_W-1:0]   rsp_down_cost,
   output logic                         rsp_left_free,
   output logic [gce_pkg::COST_W-1:0]   rsp_left_cost,
   output logic                         rsp_right_free,
   output logic [gce_pkg::COST_W-1:0]   rsp_right_cost,
   output logic [gce_pkg::COUNT_W-1:0]  rsp_free_count
);
   import gce_pkg::*;

   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [REGION_W-1:0] rows_ff, rows_in;
   logic [REGION_W-1:0] cols_ff, cols_in;
   logic                csr_wr;
   gce_cmd_type         cmd;
   gce_sts_type         sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      margin_in = margin_ff;
      size_in   = size_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      if (csr_wr) begin
         case (paddr[3:2])
            CSR_MARGIN:    margin_in = pwdata[MARGIN_W-1:0];
            CSR_CELL_SIZE: size_in   = pwdata[SIZE_W-1:0];
            CSR_ROWS:      rows_in   = pwdata[REGION_W-1:0];
            CSR_COLS:      cols_in   = pwdata[REGION_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         size_ff   <= SIZE_RESET;
         rows_ff   <= REGION_RESET;
         cols_ff   <= REGION_RESET;
      end else begin
         margin_ff <= margin_in;
         size_ff   <= size_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_MARGIN:    prdata = CSR_DW'(margin_ff);
         CSR_CELL_SIZE: prdata = CSR_DW'(size_ff);
         CSR_ROWS:      prdata = CSR_DW'(rows_ff);
         CSR_COLS:      prdata = CSR_DW'(cols_ff);
         default:       prdata = '0;
      endcase
   end

   gce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gce_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_MARGIN (MAX_MARGIN)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg_margin        (margin_ff),
      .cfg_cell_size     (size_ff),
      .cfg_rows          (rows_ff),
      .cfg_cols          (cols_ff),
      .req_type          (req_type),
      .req_cell_row      (req_cell_row),
      .req_cell_col      (req_cell_col),
      .req_cell_occupied (req_cell_occupied),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_up_free       (rsp_up_free),
      .rsp_up_cost       (rsp_up_cost),
      .rsp_down_free     (rsp_down_free),
      .rsp_down_cost     (rsp_down_cost),
      .rsp_left_free     (rsp_left_free),
      .rsp_left_cost     (rsp_left_cost),
      .rsp_right_free    (rsp_right_free),
      .rsp_right_cost    (rsp_right_cost),
      .rsp_free_count    (rsp_free_count)
   );

endmodule
